// File: src/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg: grapheme cluster boundary counter package
// Class codes, widths, state types and the pair/emoji rule functions.
// ----------------------------------------------------------------------------
package gcb_pkg;

	localparam int NumClasses = 21;
	localparam int ClassW     = 5;
	localparam int CountW     = 31;
	localparam int CfgIdxW    = 1;

	typedef logic [ClassW-1:0]     class_t;
	typedef logic [CountW-1:0]     count_t;
	typedef logic [NumClasses-1:0] class_mask_t;
	typedef logic [CfgIdxW-1:0]    cfg_idx_t;

	localparam count_t CountMax = {CountW{1'b1}};

	localparam cfg_idx_t RegMinCount = 1'b0;
	localparam cfg_idx_t RegMaxCount = 1'b1;

	localparam class_t K_OTHER     = 5'd0;
	localparam class_t K_CONS      = 5'd1;
	localparam class_t K_IEXT      = 5'd2;
	localparam class_t K_ILINK     = 5'd3;
	localparam class_t K_CR        = 5'd4;
	localparam class_t K_EXT       = 5'd5;
	localparam class_t K_EXT_IEXT  = 5'd6;
	localparam class_t K_EXT_ILINK = 5'd7;
	localparam class_t K_PICT      = 5'd8;
	localparam class_t K_L         = 5'd9;
	localparam class_t K_V         = 5'd10;
	localparam class_t K_T         = 5'd11;
	localparam class_t K_LV        = 5'd12;
	localparam class_t K_LVT       = 5'd13;
	localparam class_t K_PREP      = 5'd14;
	localparam class_t K_RI        = 5'd15;
	localparam class_t K_SMARK     = 5'd16;
	localparam class_t K_ZWJ       = 5'd17;
	localparam class_t K_ZWJ_IEXT  = 5'd18;
	localparam class_t K_LF        = 5'd19;
	localparam class_t K_CTRL      = 5'd20;

	localparam logic [1:0] IndicNone   = 2'd0;
	localparam logic [1:0] IndicCons   = 2'd1;
	localparam logic [1:0] IndicExtend = 2'd2;
	localparam logic [1:0] IndicLinker = 2'd3;

	typedef struct packed {
		logic       emoji_seq;
		logic       ri_pair;
		logic [1:0] indic;
	} rule_state_t;

	function automatic class_mask_t cbit(input class_t k);
		cbit = class_mask_t'(1) << k;
	endfunction

	function automatic class_mask_t extlike_mask();
		extlike_mask = cbit(K_EXT) | cbit(K_EXT_IEXT) | cbit(K_EXT_ILINK) |
			cbit(K_ZWJ) | cbit(K_ZWJ_IEXT);
	endfunction

	function automatic class_mask_t gb9_mask();
		gb9_mask = extlike_mask() | cbit(K_SMARK);
	endfunction

	// classes that may follow a without a break (GB3, GB6-GB9b)
	function automatic class_mask_t pair_keep(input class_t a);
		unique case (a)
			K_CR:       pair_keep = cbit(K_LF);
			K_L:        pair_keep = cbit(K_L) | cbit(K_V) | cbit(K_LV) | cbit(K_LVT) | gb9_mask();
			K_V, K_LV:  pair_keep = cbit(K_V) | cbit(K_T) | gb9_mask();
			K_T, K_LVT: pair_keep = cbit(K_T) | gb9_mask();
			K_PREP:     pair_keep = gb9_mask() | ~(cbit(K_CR) | cbit(K_LF) | cbit(K_CTRL));
			K_LF, K_CTRL: pair_keep = '0;
			default:    pair_keep = gb9_mask();
		endcase
	endfunction

	function automatic class_mask_t emoji_next(input logic flag, input class_t a);
		emoji_next = '0;
		if (a == K_PICT) begin
			emoji_next = extlike_mask();
		end else if (flag && (a == K_ZWJ || a == K_ZWJ_IEXT)) begin
			emoji_next = cbit(K_PICT);
		end else if (flag && (a == K_EXT || a == K_EXT_IEXT || a == K_EXT_ILINK)) begin
			emoji_next = extlike_mask();
		end
	endfunction

endpackage

// File: src/gcb_if.sv
// ----------------------------------------------------------------------------
// gcb_if: channel interfaces
// Input, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface gcb_in_if;
	logic            valid;
	logic            ready;
	gcb_pkg::class_t break_class;
	logic            first_item;
	logic            last_item;

	modport source (output valid, break_class, first_item, last_item, input ready);
	modport sink   (input valid, break_class, first_item, last_item, output ready);
endinterface

interface gcb_out_if;
	logic            valid;
	logic            ready;
	logic            is_boundary;
	gcb_pkg::count_t cluster_count;
	logic            count_in_range;

	modport source (output valid, is_boundary, cluster_count, count_in_range, input ready);
	modport sink   (input valid, is_boundary, cluster_count, count_in_range, output ready);
endinterface

interface gcb_cfg_if;
	logic              valid;
	logic              ready;
	gcb_pkg::cfg_idx_t index;
	gcb_pkg::count_t   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: src/gcb_rules.sv
// ----------------------------------------------------------------------------
// gcb_rules: boundary decision
// Applies the pair, emoji ZWJ, regional indicator and Indic linker rules.
// ----------------------------------------------------------------------------
module gcb_rules (
	input  gcb_pkg::class_t      prev_class,
	input  gcb_pkg::class_t      cur_class,
	input  logic                 first_item,
	input  gcb_pkg::rule_state_t cur_state,
	output gcb_pkg::rule_state_t next_state,
	output logic                 brk
);

	gcb_pkg::class_mask_t bm;
	logic                 emoji_n;
	logic                 ri_n;
	logic [1:0]           indic_n;
	logic                 keep;

	assign bm = gcb_pkg::cbit(cur_class);

	always_comb begin
		indic_n = (prev_class == gcb_pkg::K_CONS) ? gcb_pkg::IndicCons : gcb_pkg::IndicNone;
		if (cur_state.indic != gcb_pkg::IndicNone) begin
			if (prev_class == gcb_pkg::K_IEXT || prev_class == gcb_pkg::K_ZWJ_IEXT ||
				prev_class == gcb_pkg::K_EXT_IEXT) begin
				indic_n = (cur_state.indic == gcb_pkg::IndicLinker) ?
					gcb_pkg::IndicLinker : gcb_pkg::IndicExtend;
			end else if (prev_class == gcb_pkg::K_ILINK ||
				prev_class == gcb_pkg::K_EXT_ILINK) begin
				indic_n = gcb_pkg::IndicLinker;
			end
		end
	end

	assign emoji_n = |(gcb_pkg::emoji_next(cur_state.emoji_seq, prev_class) & bm);
	assign ri_n    = !cur_state.ri_pair && prev_class == gcb_pkg::K_RI &&
		cur_class == gcb_pkg::K_RI;

	assign keep = |(gcb_pkg::pair_keep(prev_class) & bm) ||
		(indic_n == gcb_pkg::IndicLinker && cur_class == gcb_pkg::K_CONS) ||
		(emoji_n && (prev_class == gcb_pkg::K_ZWJ || prev_class == gcb_pkg::K_ZWJ_IEXT) &&
			cur_class == gcb_pkg::K_PICT) ||
		ri_n;

	always_comb begin
		if (first_item) begin
			next_state = '0;
			brk        = 1'b1;
		end else begin
			next_state.emoji_seq = emoji_n && keep;
			next_state.ri_pair   = ri_n && keep;
			next_state.indic     = indic_n;
			brk                  = !keep;
		end
	end

endmodule

// File: src/grapheme_cluster_boundary_counter_top.sv
// ----------------------------------------------------------------------------
// grapheme_cluster_boundary_counter_top: grapheme cluster boundary counter
//
// din carries one code point per transaction as its break class, with
// first_item / last_item marking string edges. dout returns one result per
// input transaction: is_boundary, the saturating cluster_count and, on the
// last item, whether the count lies in [min_count, max_count]. cfg writes
// min_count (index 0) or max_count (index 1); it is always ready and must be
// used only while the block is idle.
// An input transaction passes through one input register, then the rule
// logic feeding the result register. The block takes one code point per
// cycle while dout does not stall, as set by the rule/state update loop.
// When dout stalls, the input register still takes one more transaction,
// after which din.ready drops until the result register drains.
// Reset clears the rule state, the count and the valids, and sets
// min_count to 0 and max_count to 2^31-1.
// ----------------------------------------------------------------------------
module grapheme_cluster_boundary_counter_top (
	input logic      clk,
	input logic      arst_n,
	gcb_in_if.sink   din,
	gcb_out_if.source dout,
	gcb_cfg_if.sink  cfg
);

	logic                 valid_s1;
	gcb_pkg::class_t      class_s1;
	logic                 first_s1;
	logic                 last_s1;

	gcb_pkg::class_t      prev_class_q;
	gcb_pkg::rule_state_t state_q;
	gcb_pkg::count_t      count_q;
	gcb_pkg::count_t      min_count_q;
	gcb_pkg::count_t      max_count_q;

	logic                 out_valid_q;
	logic                 is_boundary_q;
	gcb_pkg::count_t      cluster_count_q;
	logic                 range_ok_q;

	logic                 out_free;
	logic                 advance;
	gcb_pkg::class_t      class_in;
	gcb_pkg::rule_state_t state_n;
	logic                 brk;
	gcb_pkg::count_t      count_n;

	assign out_free  = !out_valid_q || dout.ready;
	assign advance   = valid_s1 && out_free;
	assign din.ready = !valid_s1 || out_free;
	assign cfg.ready = 1'b1;

	assign class_in = (din.break_class >= gcb_pkg::class_t'(gcb_pkg::NumClasses)) ?
		gcb_pkg::K_OTHER : din.break_class;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			class_s1 <= class_in;
			first_s1 <= din.first_item;
			last_s1  <= din.last_item;
		end
	end

	gcb_rules u_rules (
		.prev_class (prev_class_q),
		.cur_class  (class_s1),
		.first_item (first_s1),
		.cur_state  (state_q),
		.next_state (state_n),
		.brk        (brk)
	);

	always_comb begin
		if (first_s1) begin
			count_n = gcb_pkg::count_t'(1);
		end else if (brk && count_q != gcb_pkg::CountMax) begin
			count_n = count_q + gcb_pkg::count_t'(1);
		end else begin
			count_n = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_class_q <= gcb_pkg::K_OTHER;
			state_q      <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				prev_class_q <= class_s1;
				state_q      <= state_n;
				count_q      <= count_n;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			is_boundary_q   <= brk;
			cluster_count_q <= count_n;
			range_ok_q      <= last_s1 && count_n >= min_count_q && count_n <= max_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_count_q <= '0;
			max_count_q <= gcb_pkg::CountMax;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				gcb_pkg::RegMinCount: min_count_q <= cfg.data;
				gcb_pkg::RegMaxCount: max_count_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign dout.valid          = out_valid_q;
	assign dout.is_boundary    = is_boundary_q;
	assign dout.cluster_count  = cluster_count_q;
	assign dout.count_in_range = range_ok_q;

endmodule

// File: tb/grapheme_cluster_boundary_counter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grapheme_cluster_boundary_counter_top_tb: cluster boundary counter testbench
// Sends code point classes as strings, mostly well-formed rule sequences
// (emoji ZWJ, regional indicator runs, Indic conjuncts, Hangul syllables) plus
// noise and broken framing. An in-bench model predicts boundary, count and
// range flag for each transaction and a scoreboard checks every result.
// Runs through several range settings and idle/stall mixes, including a long
// output hold-off that backs the input up.
// ----------------------------------------------------------------------------
module grapheme_cluster_boundary_counter_top_tb;
	import gcb_pkg::*;

	localparam class_t ClassUndefTop = 5'd31;
	localparam int     HoldCycles    = 80;

	localparam int SegEmoji    = 0;
	localparam int SegRegional = 1;
	localparam int SegIndic    = 2;
	localparam int SegHangul   = 3;
	localparam int SegControl  = 4;
	localparam int SegMixed    = 5;
	localparam int SegNoise    = 6;
	localparam int SegLast     = 7;

	typedef struct packed {
		logic   brk;
		count_t cnt;
		logic   range_ok;
	} cluster_result_t;

	class cluster_scoreboard;
		class_t          prev_cls;
		logic            emoji_seq;
		logic            ri_pair;
		logic [1:0]      indic;
		count_t          run_cnt;
		count_t          min_cnt;
		count_t          max_cnt;
		cluster_result_t expected_clusters[$];
		int              errors;

		function new();
			prev_cls  = K_OTHER;
			emoji_seq = 1'b0;
			ri_pair   = 1'b0;
			indic     = IndicNone;
			run_cnt   = '0;
			min_cnt   = '0;
			max_cnt   = CountMax;
			errors    = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, count_t val);
			if (idx == RegMinCount) begin
				min_cnt = val;
			end else begin
				max_cnt = val;
			end
		endfunction

		function bit is_extlike(class_t k);
			return k == K_EXT || k == K_EXT_IEXT || k == K_EXT_ILINK ||
				k == K_ZWJ || k == K_ZWJ_IEXT;
		endfunction

		function bit pair_keeps(class_t a, class_t b);
			bit gb9;
			gb9 = is_extlike(b) || b == K_SMARK;
			case (a)
				K_CR:         return b == K_LF;
				K_LF, K_CTRL: return 1'b0;
				K_L:          return gb9 || b == K_L || b == K_V || b == K_LV || b == K_LVT;
				K_V, K_LV:    return gb9 || b == K_V || b == K_T;
				K_T, K_LVT:   return gb9 || b == K_T;
				K_PREP:       return !(b == K_CR || b == K_LF || b == K_CTRL);
				default:      return gb9;
			endcase
		endfunction

		function bit emoji_follows(bit flag, class_t a, class_t b);
			if (a == K_PICT)
				return is_extlike(b);
			if (flag && (a == K_ZWJ || a == K_ZWJ_IEXT))
				return b == K_PICT;
			if (flag && (a == K_EXT || a == K_EXT_IEXT || a == K_EXT_ILINK))
				return is_extlike(b);
			return 1'b0;
		endfunction

		function logic [1:0] indic_step(logic [1:0] s, class_t a);
			if (s != IndicNone) begin
				if (a == K_IEXT || a == K_ZWJ_IEXT || a == K_EXT_IEXT)
					return (s == IndicLinker) ? IndicLinker : IndicExtend;
				if (a == K_ILINK || a == K_EXT_ILINK)
					return IndicLinker;
			end
			return (a == K_CONS) ? IndicCons : IndicNone;
		endfunction

		function void note_code_point(class_t raw, bit f, bit l);
			class_t          c;
			bit              keep;
			cluster_result_t r;
			c = (raw >= NumClasses) ? K_OTHER : raw;
			if (f) begin
				emoji_seq = 1'b0;
				ri_pair   = 1'b0;
				indic     = IndicNone;
				run_cnt   = count_t'(1);
				r.brk     = 1'b1;
			end else begin
				emoji_seq = emoji_follows(emoji_seq, prev_cls, c);
				ri_pair   = !ri_pair && prev_cls == K_RI && c == K_RI;
				indic     = indic_step(indic, prev_cls);
				keep = pair_keeps(prev_cls, c) || (indic == IndicLinker && c == K_CONS) ||
					(emoji_seq && (prev_cls == K_ZWJ || prev_cls == K_ZWJ_IEXT) &&
					c == K_PICT) || ri_pair;
				if (!keep) begin
					emoji_seq = 1'b0;
					ri_pair   = 1'b0;
					if (run_cnt != CountMax)
						run_cnt = run_cnt + 1'b1;
				end
				r.brk = !keep;
			end
			prev_cls   = c;
			r.cnt      = run_cnt;
			r.range_ok = l && run_cnt >= min_cnt && run_cnt <= max_cnt;
			expected_clusters.push_back(r);
		endfunction

		function void check_result(logic brk, count_t cnt, logic range_ok);
			cluster_result_t e;
			if (expected_clusters.size() == 0) begin
				$display("%0t: unexpected result is_boundary=%0b cluster_count=%0d count_in_range=%0b",
					$time, brk, cnt, range_ok);
				errors++;
				return;
			end
			e = expected_clusters.pop_front();
			if (brk !== e.brk) begin
				$display("%0t: is_boundary expected %0b, got %0b", $time, e.brk, brk);
				errors++;
			end
			if (cnt !== e.cnt) begin
				$display("%0t: cluster_count expected %0d, got %0d", $time, e.cnt, cnt);
				errors++;
			end
			if (range_ok !== e.range_ok) begin
				$display("%0t: count_in_range expected %0b, got %0b", $time, e.range_ok,
					range_ok);
				errors++;
			end
		endfunction

		function int pending();
			return expected_clusters.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	gcb_in_if  din();
	gcb_out_if dout();
	gcb_cfg_if cfg();

	grapheme_cluster_boundary_counter_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din),
		.dout  (dout),
		.cfg   (cfg)
	);

	cluster_scoreboard sb = new();

	int     src_idle_pct;
	int     snk_stall_pct;
	bit     hold_req;
	class_t str_buf[$];

	class_t ext_pool[3]    = '{K_EXT, K_EXT_IEXT, K_EXT_ILINK};
	class_t zwj_pool[2]    = '{K_ZWJ, K_ZWJ_IEXT};
	class_t iext_pool[5]   = '{K_IEXT, K_EXT_IEXT, K_ZWJ_IEXT, K_EXT, K_ZWJ};
	class_t link_pool[2]   = '{K_ILINK, K_EXT_ILINK};
	class_t hangul_pool[5] = '{K_L, K_V, K_T, K_LV, K_LVT};
	class_t ctl_pool[6]    = '{K_CR, K_LF, K_CTRL, K_PREP, K_SMARK, K_OTHER};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("grapheme_cluster_boundary_counter_top_tb: done, errors");
		$finish;
	end

	// output side: random stalls, or a counted hold-off on request
	initial begin
		dout.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				dout.ready <= 1'b0;
				repeat (HoldCycles - 1) @(posedge clk);
			end else begin
				dout.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && dout.valid && dout.ready)
			sb.check_result(dout.is_boundary, dout.cluster_count, dout.count_in_range);
	end

	task automatic send_item(class_t c, bit f, bit l);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid       <= 1'b1;
		din.break_class <= c;
		din.first_item  <= f;
		din.last_item   <= l;
		@(posedge clk);
		while (!din.ready) @(posedge clk);
		sb.note_code_point(c, f, l);
	endtask

	task automatic send_string(bit broken);
		bit f;
		bit l;
		for (int i = 0; i < str_buf.size(); i++) begin
			f = (i == 0);
			l = (i == str_buf.size() - 1);
			if (broken) begin
				f = ($urandom_range(3) == 0);
				l = ($urandom_range(3) == 0);
			end
			send_item(str_buf[i], f, l);
		end
	endtask

	task automatic end_burst();
		din.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_range(count_t min_val, count_t max_val);
		cfg.valid <= 1'b1;
		cfg.index <= RegMinCount;
		cfg.data  <= min_val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sb.set_reg(RegMinCount, min_val);
		cfg.index <= RegMaxCount;
		cfg.data  <= max_val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sb.set_reg(RegMaxCount, max_val);
		cfg.valid <= 1'b0;
	endtask

	task automatic add_segment(int mode);
		case (mode)
			SegRegional: begin
				repeat ($urandom_range(1, 5)) str_buf.push_back(K_RI);
			end
			SegIndic: begin
				str_buf.push_back(K_CONS);
				repeat ($urandom_range(1, 2)) begin
					repeat ($urandom_range(2)) str_buf.push_back(iext_pool[$urandom_range(4)]);
					str_buf.push_back(link_pool[$urandom_range(1)]);
					repeat ($urandom_range(1)) str_buf.push_back(iext_pool[$urandom_range(2)]);
					str_buf.push_back(K_CONS);
				end
			end
			SegHangul: begin
				repeat ($urandom_range(1, 5)) str_buf.push_back(hangul_pool[$urandom_range(4)]);
			end
			SegControl: begin
				repeat ($urandom_range(1, 4)) str_buf.push_back(ctl_pool[$urandom_range(5)]);
			end
			SegMixed: begin
				repeat ($urandom_range(1, 5)) str_buf.push_back(class_t'($urandom_range(20)));
			end
			SegNoise: begin
				repeat ($urandom_range(1, 4)) str_buf.push_back(class_t'($urandom_range(31)));
			end
			default: begin
				str_buf.push_back(K_PICT);
				repeat ($urandom_range(2)) str_buf.push_back(ext_pool[$urandom_range(2)]);
				repeat ($urandom_range(2)) begin
					str_buf.push_back(zwj_pool[$urandom_range(1)]);
					repeat ($urandom_range(1)) str_buf.push_back(ext_pool[$urandom_range(2)]);
					str_buf.push_back(K_PICT);
				end
			end
		endcase
	endtask

	task automatic run_random(int n);
		int done;
		done = 0;
		while (done < n) begin
			str_buf.delete();
			repeat ($urandom_range(1, 3)) add_segment($urandom_range(SegLast));
			send_string($urandom_range(9) == 0);
			done += str_buf.size();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		din.valid       = 1'b0;
		din.break_class = K_OTHER;
		din.first_item  = 1'b0;
		din.last_item   = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = RegMinCount;
		cfg.data        = '0;
		src_idle_pct    = 0;
		snk_stall_pct   = 0;
		hold_req        = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_range('0, CountMax);

		// no first item after reset, then one string per rule family
		send_item(K_EXT, 1'b0, 1'b0);
		send_item(ClassUndefTop, 1'b0, 1'b1);
		str_buf = '{K_OTHER};
		send_string(1'b0);
		str_buf = '{K_CR, K_LF, K_CTRL, K_LF};
		send_string(1'b0);
		str_buf = '{K_PICT, K_EXT_IEXT, K_ZWJ, K_PICT};
		send_string(1'b0);
		str_buf = '{K_RI, K_RI, K_RI};
		send_string(1'b0);
		str_buf = '{K_CONS, K_EXT_ILINK, K_IEXT, K_CONS};
		send_string(1'b0);
		str_buf = '{K_L, K_V, K_T, K_LVT};
		send_string(1'b0);
		str_buf = '{K_PREP, K_SMARK, K_CR};
		send_string(1'b0);
		end_burst();
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct  = 0;
					snk_stall_pct = 0;
					write_range('0, CountMax);
				end
				1: begin
					src_idle_pct  = 67;
					snk_stall_pct = 0;
					write_range(count_t'($urandom_range(1, 3)), count_t'($urandom_range(3, 6)));
				end
				2: begin
					src_idle_pct  = 0;
					snk_stall_pct = 67;
					write_range(CountMax, '0);
				end
				default: begin
					src_idle_pct  = 34;
					snk_stall_pct = 34;
					write_range(count_t'($urandom_range(2, 4)), count_t'($urandom_range(2, 4)));
				end
			endcase
			run_random(100);
			end_burst();
			wait_idle();
		end

		// output held off while input keeps coming
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		write_range(count_t'($urandom_range(1, 2)), count_t'($urandom_range(2, 6)));
		hold_req = 1'b1;
		run_random(40);
		end_burst();
		wait_idle();

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("grapheme_cluster_boundary_counter_top_tb: done, clean");
		end else begin
			$display("grapheme_cluster_boundary_counter_top_tb: done, errors");
		end
		$finish;
	end

endmodule
